/* rtl/ngga_pkg.sv */
// Shared types, constants and helpers for the GGA sentence field extractor.
package ngga_pkg;

    // Overflow limit on characters within one field
    localparam logic [3:0] FIELD_CHAR_LIMIT = 4'd12;

    // Default depth of the command queue between front and back
    localparam int CMDQ_DEPTH_DEF = 4;

    // Storage depths of the character stores
    localparam logic [3:0] TIME_DEPTH = 4'd10;
    localparam logic [3:0] LAT_DEPTH  = 4'd9;
    localparam logic [3:0] LON_DEPTH  = 4'd10;

    // Header length and last field index
    localparam logic [2:0] HDR_LEN   = 3'd6;
    localparam logic [2:0] FIELD_MAX = 3'd7;

    // Field numbers within the sentence
    localparam logic [2:0] FLD_TIME     = 3'd1;
    localparam logic [2:0] FLD_LAT      = 3'd2;
    localparam logic [2:0] FLD_LAT_HEMI = 3'd3;
    localparam logic [2:0] FLD_LON      = 3'd4;
    localparam logic [2:0] FLD_LON_HEMI = 3'd5;
    localparam logic [2:0] FLD_FIX      = 3'd6;

    // Special characters
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ONE   = 8'h31;

    // Reset contents of the character stores
    localparam logic [0:9][7:0] TIME_INIT = "000000.000";
    localparam logic [0:8][7:0] LAT_INIT  = "0000.0000";
    localparam logic [0:9][7:0] LON_INIT  = "00000.0000";
    localparam logic [7:0]      LAT_HEMI_INIT = "N";
    localparam logic [7:0]      LON_HEMI_INIT = "W";

    // Parser mode
    typedef enum logic [1:0] {
        MODE_SYNC  = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_CHECK = 2'd2
    } t_mode;

    // Store operation carried by one command
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TIME,
        OP_LAT_STAGE,
        OP_LAT_COMMIT,
        OP_LAT_HEMI,
        OP_LON_STAGE,
        OP_LON_COMMIT,
        OP_LON_HEMI,
        OP_FIX
    } t_op;

    // One classified byte, handed from front to back
    typedef struct packed {
        t_op        op;
        logic [3:0] pos;
        logic [7:0] data;
        logic       ended;
        logic       bad;
    } t_cmd;

    // Header character at a given position
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "$";
            3'd1:    ch = "G";
            3'd2:    ch = "P";
            3'd3:    ch = "G";
            3'd4:    ch = "G";
            3'd5:    ch = "A";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/nmea_gga_field_extractor.sv */
// Top level of the GGA sentence field extractor.
// A pushed byte is written into the command queue, then taken into the stores and the
// result registers (empty low), with the queue and the shown result clear.
// Throughput: one byte per cycle unless full; front and back end each take one request
// a cycle, decoupled by the queue; the back waits while the held result is not popped.
// Reset (synchronous, active low): parser hunts for the header, queue and result
// empty, character stores back to their zero strings, N, W and no fix.
module nmea_gga_field_extractor #(
    parameter int CMDQ_DEPTH = ngga_pkg::CMDQ_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [39:0] o_time_hi,
    output logic [39:0] o_time_lo,
    output logic [39:0] o_lat_hi,
    output logic [31:0] o_lat_lo,
    output logic [7:0]  o_lat_letter,
    output logic [39:0] o_lon_hi,
    output logic [39:0] o_lon_lo,
    output logic [7:0]  o_lon_letter,
    output logic        o_has_fix,
    output logic        o_sentence_end,
    output logic        o_corrupt
);

    ngga_pkg::t_cmd front_cmd, q_cmd;
    logic           in_req, q_empty, q_take;

    assign in_req = push && !full;

    // Byte classification
    ngga_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (in_req),
        .i_rx_byte (i_rx_byte),
        .o_cmd     (front_cmd)
    );

    // Command queue
    ngga_cmd_fifo #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (front_cmd),
        .o_full  (full),
        .i_rd    (q_take),
        .o_rdata (q_cmd),
        .o_empty (q_empty)
    );

    // Stores and result
    ngga_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_avail    (!q_empty),
        .i_cmd          (q_cmd),
        .o_cmd_take     (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_time_hi      (o_time_hi),
        .o_time_lo      (o_time_lo),
        .o_lat_hi       (o_lat_hi),
        .o_lat_lo       (o_lat_lo),
        .o_lat_letter   (o_lat_letter),
        .o_lon_hi       (o_lon_hi),
        .o_lon_lo       (o_lon_lo),
        .o_lon_letter   (o_lon_letter),
        .o_has_fix      (o_has_fix),
        .o_sentence_end (o_sentence_end),
        .o_corrupt      (o_corrupt)
    );

endmodule

/* rtl/ngga_front.sv */
// Front end: header match, field and character counting, byte classification.
module ngga_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req,
    input  logic [7:0]      i_rx_byte,
    output ngga_pkg::t_cmd  o_cmd
);

    ngga_pkg::t_mode r_mode, n_mode;
    logic [2:0]      r_hdr_pos, n_hdr_pos;
    logic [2:0]      r_field, n_field;
    logic [3:0]      r_char_pos, n_char_pos;

    // Parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ngga_pkg::MODE_SYNC;
            r_hdr_pos  <= 3'd0;
            r_field    <= 3'd0;
            r_char_pos <= 4'd0;
        end else if (i_req) begin
            r_mode     <= n_mode;
            r_hdr_pos  <= n_hdr_pos;
            r_field    <= n_field;
            r_char_pos <= n_char_pos;
        end
    end

    // Next state and command for the byte on offer
    always_comb begin
        n_mode     = r_mode;
        n_hdr_pos  = r_hdr_pos;
        n_field    = r_field;
        n_char_pos = r_char_pos;
        o_cmd.op    = ngga_pkg::OP_NONE;
        o_cmd.pos   = r_char_pos;
        o_cmd.data  = i_rx_byte;
        o_cmd.ended = 1'b0;
        o_cmd.bad   = 1'b0;
        case (r_mode)
            ngga_pkg::MODE_DATA: begin
                if (i_rx_byte == ngga_pkg::CH_COMMA) begin
                    n_char_pos = 4'd0;
                    if (r_field == ngga_pkg::FLD_LAT) begin
                        o_cmd.op = ngga_pkg::OP_LAT_COMMIT;
                    end else if (r_field == ngga_pkg::FLD_LON) begin
                        o_cmd.op = ngga_pkg::OP_LON_COMMIT;
                    end
                    if (r_field != ngga_pkg::FIELD_MAX) begin
                        n_field = r_field + 3'd1;
                    end
                end else if (i_rx_byte == ngga_pkg::CH_STAR) begin
                    n_field     = 3'd0;
                    n_char_pos  = 4'd0;
                    n_mode      = ngga_pkg::MODE_CHECK;
                    o_cmd.ended = 1'b1;
                end else if (r_char_pos >= ngga_pkg::FIELD_CHAR_LIMIT) begin
                    // field overflow: drop the byte and hunt for a header again
                    n_mode     = ngga_pkg::MODE_SYNC;
                    n_hdr_pos  = 3'd0;
                    n_field    = 3'd0;
                    n_char_pos = 4'd0;
                    o_cmd.bad  = 1'b1;
                end else begin
                    case (r_field)
                        ngga_pkg::FLD_TIME: begin
                            if (r_char_pos < ngga_pkg::TIME_DEPTH) begin
                                o_cmd.op = ngga_pkg::OP_TIME;
                            end
                        end
                        ngga_pkg::FLD_LAT: begin
                            if (r_char_pos < ngga_pkg::LAT_DEPTH) begin
                                o_cmd.op = ngga_pkg::OP_LAT_STAGE;
                            end
                        end
                        ngga_pkg::FLD_LAT_HEMI: o_cmd.op = ngga_pkg::OP_LAT_HEMI;
                        ngga_pkg::FLD_LON: begin
                            if (r_char_pos < ngga_pkg::LON_DEPTH) begin
                                o_cmd.op = ngga_pkg::OP_LON_STAGE;
                            end
                        end
                        ngga_pkg::FLD_LON_HEMI: o_cmd.op = ngga_pkg::OP_LON_HEMI;
                        ngga_pkg::FLD_FIX:      o_cmd.op = ngga_pkg::OP_FIX;
                        default:                o_cmd.op = ngga_pkg::OP_NONE;
                    endcase
                    n_char_pos = r_char_pos + 4'd1;
                end
            end
            ngga_pkg::MODE_CHECK: begin
                // byte after the star is skipped
                n_mode     = ngga_pkg::MODE_SYNC;
                n_hdr_pos  = 3'd0;
                n_field    = 3'd0;
                n_char_pos = 4'd0;
            end
            default: begin
                n_mode = ngga_pkg::MODE_SYNC;
                if (r_hdr_pos < ngga_pkg::HDR_LEN &&
                    i_rx_byte == ngga_pkg::hdr_char(r_hdr_pos)) begin
                    if (r_hdr_pos == ngga_pkg::HDR_LEN - 3'd1) begin
                        n_mode     = ngga_pkg::MODE_DATA;
                        n_hdr_pos  = 3'd0;
                        n_field    = 3'd0;
                        n_char_pos = 4'd0;
                    end else begin
                        n_hdr_pos = r_hdr_pos + 3'd1;
                    end
                end else begin
                    n_hdr_pos = 3'd0;
                end
            end
        endcase
    end

endmodule

/* rtl/ngga_cmd_fifo.sv */
// Short command queue between the front end and the store back end.
module ngga_cmd_fifo #(
    parameter int DEPTH = ngga_pkg::CMDQ_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  ngga_pkg::t_cmd  i_wdata,
    output logic            o_full,
    input  logic            i_rd,
    output ngga_pkg::t_cmd  o_rdata,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ngga_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

/* rtl/ngga_back.sv */
// Back end: character stores, commit copies and the held result.
module ngga_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_avail,
    input  ngga_pkg::t_cmd  i_cmd,
    output logic            o_cmd_take,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [39:0]     o_time_hi,
    output logic [39:0]     o_time_lo,
    output logic [39:0]     o_lat_hi,
    output logic [31:0]     o_lat_lo,
    output logic [7:0]      o_lat_letter,
    output logic [39:0]     o_lon_hi,
    output logic [39:0]     o_lon_lo,
    output logic [7:0]      o_lon_letter,
    output logic            o_has_fix,
    output logic            o_sentence_end,
    output logic            o_corrupt
);

    logic [0:9][7:0] r_time;
    logic [0:8][7:0] r_lat_stage, r_lat;
    logic [0:9][7:0] r_lon_stage, r_lon;
    logic [7:0]      r_lat_hemi, r_lon_hemi;
    logic            r_fix, r_ended, r_bad, r_valid;

    // The stores stay put until the shown result is taken
    assign o_cmd_take = i_cmd_avail && (!r_valid || i_pop);
    assign o_empty    = !r_valid;

    // Result valid and per-request flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ended <= 1'b0;
            r_bad   <= 1'b0;
        end else if (o_cmd_take) begin
            r_valid <= 1'b1;
            r_ended <= i_cmd.ended;
            r_bad   <= i_cmd.bad;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Character stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= ngga_pkg::TIME_INIT;
            r_lat_stage <= ngga_pkg::LAT_INIT;
            r_lat       <= ngga_pkg::LAT_INIT;
            r_lon_stage <= ngga_pkg::LON_INIT;
            r_lon       <= ngga_pkg::LON_INIT;
            r_lat_hemi  <= ngga_pkg::LAT_HEMI_INIT;
            r_lon_hemi  <= ngga_pkg::LON_HEMI_INIT;
            r_fix       <= 1'b0;
        end else if (o_cmd_take) begin
            case (i_cmd.op)
                ngga_pkg::OP_TIME:       r_time[i_cmd.pos]      <= i_cmd.data;
                ngga_pkg::OP_LAT_STAGE:  r_lat_stage[i_cmd.pos] <= i_cmd.data;
                ngga_pkg::OP_LAT_COMMIT: r_lat                  <= r_lat_stage;
                ngga_pkg::OP_LAT_HEMI:   r_lat_hemi             <= i_cmd.data;
                ngga_pkg::OP_LON_STAGE:  r_lon_stage[i_cmd.pos] <= i_cmd.data;
                ngga_pkg::OP_LON_COMMIT: r_lon                  <= r_lon_stage;
                ngga_pkg::OP_LON_HEMI:   r_lon_hemi             <= i_cmd.data;
                ngga_pkg::OP_FIX:        r_fix <= (i_cmd.data == ngga_pkg::CH_ONE);
                default: ;
            endcase
        end
    end

    // Result fields, first character in the top byte
    assign o_time_hi      = r_time[0:4];
    assign o_time_lo      = r_time[5:9];
    assign o_lat_hi       = r_lat[0:4];
    assign o_lat_lo       = r_lat[5:8];
    assign o_lat_letter   = r_lat_hemi;
    assign o_lon_hi       = r_lon[0:4];
    assign o_lon_lo       = r_lon[5:9];
    assign o_lon_letter   = r_lon_hemi;
    assign o_has_fix      = r_fix;
    assign o_sentence_end = r_ended;
    assign o_corrupt      = r_bad;

endmodule
